// File: src/tbes_pkg.sv
// ----------------------------------------------------------------------------
// tbes_pkg: shared types and codes for the timer bank expiry scan
// Command codes, register indexes, tick word and the adder request bundle.
// ----------------------------------------------------------------------------
package tbes_pkg;

  localparam int MASK_W = 8;   // width of the registered and handler masks
  localparam int WORD_W = 32;  // tick counter, period and deadline width

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START_ONE = 3'd1;
  localparam logic [2:0] CMD_START_PER = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_QUERY     = 3'd4;
  localparam logic [2:0] CMD_PROCESS   = 3'd5;

  localparam logic REG_REGISTERED = 1'b0;
  localparam logic REG_HANDLER    = 1'b1;

  // request to the shared add/subtract unit
  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } alu_req_t;

endpackage

// File: src/tbes_addsub.sv
// ----------------------------------------------------------------------------
// tbes_addsub: shared 32-bit add/subtract unit
// One adder serves tick increment, deadline arming, expiry test and reload.
// ----------------------------------------------------------------------------
module tbes_addsub (
  input  tbes_pkg::alu_req_t req,
  output tbes_pkg::word_t    y
);
  import tbes_pkg::*;

  word_t b_eff;

  // subtract as a + ~b + 1
  assign b_eff = req.sub ? ~req.b : req.b;
  assign y     = req.a + b_eff + word_t'(req.sub);

endmodule

// File: src/tbes_timer_ram.sv
// ----------------------------------------------------------------------------
// tbes_timer_ram: deadline and period storage
// One write port, one read port per array, registered read data.
// ----------------------------------------------------------------------------
module tbes_timer_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic              clk,
  input  logic              dl_we,
  input  logic              pd_we,
  input  logic [AW-1:0]     wr_addr,
  input  tbes_pkg::word_t   dl_wdata,
  input  tbes_pkg::word_t   pd_wdata,
  input  logic [AW-1:0]     rd_addr,
  output tbes_pkg::word_t   dl_rdata,
  output tbes_pkg::word_t   pd_rdata
);
  import tbes_pkg::*;

  word_t deadline_mem [DEPTH];
  word_t period_mem   [DEPTH];
  word_t dl_rdata_r;
  word_t pd_rdata_r;

  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_mem[wr_addr] <= dl_wdata;
    end
    if (pd_we) begin
      period_mem[wr_addr] <= pd_wdata;
    end
    // read-before-write on a shared address
    dl_rdata_r <= deadline_mem[rd_addr];
    pd_rdata_r <= period_mem[rd_addr];
  end

  assign dl_rdata = dl_rdata_r;
  assign pd_rdata = pd_rdata_r;

endmodule

// File: src/timer_bank_expiry_scan.sv
// ----------------------------------------------------------------------------
// timer_bank_expiry_scan: bank of millisecond timers with expiry scan
// Free-running tick counter, one-shot and periodic timers, in-order scan.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Tick, start,
// stop, query and unused commands finish in the accept cycle; their single
// result is strobed on the following cycle and busy never rises. A process
// command holds busy while it visits min(NUM_TIMERS, 8) timers one per
// cycle, save that each periodic timer that expires in the scan holds the
// scan for a second pass through the shared adder to reload its deadline,
// and then for a closing step; the last result strobes in the first
// cycle that busy is low. The pace is set by the single 32-bit add/subtract
// unit and the single read port of the deadline/period memory. Results are
// strobed for exactly one cycle and cannot be held off, so the receiver must
// take every out_strobe. Fire results come in ascending index order, the
// final one marked by out_last; a scan with nothing to report gives one empty
// result. Only the eight timers that the masks cover can ever be armed, so
// storage is sized to the lesser of NUM_TIMERS and eight. Memory contents are
// not cleared at reset: an entry's data is used only once a start has written it.
// ----------------------------------------------------------------------------
module timer_bank_expiry_scan #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_command,
  input  logic [2:0]          in_timer_index,
  input  tbes_pkg::word_t     in_period_ms,
  // result channel
  output logic                out_strobe,
  output logic                out_accepted,
  output logic                out_active_flag,
  output logic                out_fired,
  output logic [2:0]          out_fired_index,
  output logic                out_last,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  tbes_pkg::mask_t     cfg_data
);
  import tbes_pkg::*;

  // timers reachable through the 8-bit masks and 3-bit index
  localparam int SCAN_N = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;
  localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHK  = 2'd1;  // expiry test of one timer
  localparam logic [1:0] ST_UPD  = 2'd2;  // periodic deadline reload
  localparam logic [1:0] ST_FIN  = 2'd3;  // flush held fire / empty result

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_N - 1);

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic              pend_v_r, pend_v_nxt;     // a fire is held back
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  word_t             now_r, now_nxt;
  mask_t             reg_mask_r, reg_mask_nxt;
  mask_t             hdl_mask_r, hdl_mask_nxt;
  logic [SCAN_N-1:0] active_r, active_nxt;
  logic [SCAN_N-1:0] periodic_r, periodic_nxt;

  logic              strobe_r, strobe_nxt;
  logic              acc_r, acc_nxt;
  logic              act_r, act_nxt;
  logic              fir_r, fir_nxt;
  logic [2:0]        fidx_r, fidx_nxt;
  logic              last_r, last_nxt;

  alu_req_t          alu_req;
  word_t             alu_y;

  logic              dl_we, pd_we;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  word_t             dl_wdata;
  word_t             dl_rdata, pd_rdata;

  logic [IDX_W-1:0]  cmd_idx;
  logic              idx_ok;
  logic [IDX_W-1:0]  scan_inc;
  logic              is_last;
  logic              expired;
  logic              go_upd;
  mask_t             newly;

  tbes_addsub u_addsub (
    .req (alu_req),
    .y   (alu_y)
  );

  tbes_timer_ram #(
    .DEPTH (SCAN_N),
    .AW    (IDX_W)
  ) u_ram (
    .clk      (clk),
    .dl_we    (dl_we),
    .pd_we    (pd_we),
    .wr_addr  (wr_addr),
    .dl_wdata (dl_wdata),
    .pd_wdata (in_period_ms),
    .rd_addr  (rd_addr),
    .dl_rdata (dl_rdata),
    .pd_rdata (pd_rdata)
  );

  assign cmd_idx  = in_timer_index[IDX_W-1:0];
  assign idx_ok   = 32'(in_timer_index) < 32'(SCAN_N);
  assign scan_inc = scan_r + 1'b1;
  assign is_last  = (scan_r == LAST_IDX);
  assign newly    = cfg_data & ~reg_mask_r;
  assign dl_wdata = alu_y;

  // expiry test: registered, active and (now - deadline) not negative
  assign expired = reg_mask_r[scan_r] && active_r[scan_r] && !alu_y[WORD_W-1];
  assign go_upd  = expired && periodic_r[scan_r];

  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    now_nxt      = now_r;
    reg_mask_nxt = reg_mask_r;
    hdl_mask_nxt = hdl_mask_r;
    active_nxt   = active_r;
    periodic_nxt = periodic_r;

    strobe_nxt = 1'b0;
    acc_nxt    = 1'b0;
    act_nxt    = 1'b0;
    fir_nxt    = 1'b0;
    fidx_nxt   = 3'd0;
    last_nxt   = 1'b0;

    alu_req = '{a: now_r, b: word_t'(1), sub: 1'b0};
    dl_we   = 1'b0;
    pd_we   = 1'b0;
    wr_addr = scan_r;
    rd_addr = '0;   // idle: prefetch timer 0 for a process command

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          unique case (in_command) inside
            CMD_TICK: begin
              now_nxt = alu_y;
              acc_nxt = 1'b1;
            end
            CMD_START_ONE, CMD_START_PER: begin
              alu_req.b = in_period_ms;
              if (idx_ok && (in_period_ms != '0) && hdl_mask_r[in_timer_index]) begin
                dl_we   = 1'b1;
                pd_we   = 1'b1;
                wr_addr = cmd_idx;
                active_nxt[cmd_idx]   = 1'b1;
                periodic_nxt[cmd_idx] = (in_command == CMD_START_PER);
                acc_nxt = 1'b1;
              end
            end
            CMD_STOP: begin
              if (idx_ok) begin
                active_nxt[cmd_idx] = 1'b0;
              end
              acc_nxt = 1'b1;
            end
            CMD_QUERY: begin
              acc_nxt = 1'b1;
              act_nxt = idx_ok && active_r[cmd_idx];
            end
            CMD_PROCESS: begin
              strobe_nxt = 1'b0;
              last_nxt   = 1'b0;
              state_nxt  = ST_CHK;
              scan_nxt   = '0;
              pend_v_nxt = 1'b0;
            end
            default: begin
              acc_nxt = 1'b0;   // unused code: rejected
            end
          endcase
        end
      end

      ST_CHK: begin
        alu_req = '{a: now_r, b: dl_rdata, sub: 1'b1};
        if (expired && !periodic_r[scan_r]) begin
          active_nxt[scan_r] = 1'b0;
        end
        // fires are held back until the next one or the closing step so the final one can carry last
        if (expired && hdl_mask_r[scan_r]) begin
          if (pend_v_r) begin
            strobe_nxt = 1'b1;
            acc_nxt    = 1'b1;
            fir_nxt    = 1'b1;
            fidx_nxt   = 3'(pend_idx_r);
          end
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = scan_r;
        end
        if (go_upd) begin
          rd_addr   = scan_r;   // keep this timer's data for the reload
          state_nxt = ST_UPD;
        end else if (is_last) begin
          rd_addr   = scan_r;
          state_nxt = ST_FIN;
        end else begin
          rd_addr  = scan_inc;
          scan_nxt = scan_inc;
        end
      end

      ST_UPD: begin
        alu_req = '{a: dl_rdata, b: pd_rdata, sub: 1'b0};
        dl_we   = 1'b1;
        wr_addr = scan_r;
        if (is_last) begin
          rd_addr   = scan_r;
          state_nxt = ST_FIN;
        end else begin
          rd_addr   = scan_inc;
          scan_nxt  = scan_inc;
          state_nxt = ST_CHK;
        end
      end

      ST_FIN: begin
        strobe_nxt = 1'b1;
        acc_nxt    = 1'b1;
        last_nxt   = 1'b1;
        fir_nxt    = pend_v_r;
        fidx_nxt   = pend_v_r ? 3'(pend_idx_r) : 3'd0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes must arrive only while idle; the block does not enforce this
    if (cfg_we) begin
      unique case (cfg_index)
        REG_REGISTERED: begin
          active_nxt   = active_nxt & ~newly[SCAN_N-1:0];
          reg_mask_nxt = cfg_data;
        end
        REG_HANDLER: begin
          hdl_mask_nxt = cfg_data;
        end
        default: begin
          hdl_mask_nxt = hdl_mask_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_r     <= '0;
      pend_v_r   <= 1'b0;
      now_r      <= '0;
      reg_mask_r <= '0;
      hdl_mask_r <= '0;
      active_r   <= '0;
      periodic_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_r     <= scan_nxt;
      pend_v_r   <= pend_v_nxt;
      now_r      <= now_nxt;
      reg_mask_r <= reg_mask_nxt;
      hdl_mask_r <= hdl_mask_nxt;
      active_r   <= active_nxt;
      periodic_r <= periodic_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    acc_r      <= acc_nxt;
    act_r      <= act_nxt;
    fir_r      <= fir_nxt;
    fidx_r     <= fidx_nxt;
    last_r     <= last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_accepted    = acc_r;
  assign out_active_flag = act_r;
  assign out_fired       = fir_r;
  assign out_fired_index = fidx_r;
  assign out_last        = last_r;

`ifndef SYNTHESIS
  // a reload pass only ever follows an expiry test
  a_upd_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == ST_UPD) |-> $past(state_r) == ST_CHK)
    else $error("reload pass without preceding expiry test");

  // the closing step always strobes a final result
  a_fin_strobes_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) == ST_FIN) |-> (out_strobe && out_last))
    else $error("scan closed without final result");

  // busy rises only on an accepted process command
  a_busy_on_process: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(busy)) |->
      ($past(start) && $past(in_command) == CMD_PROCESS))
    else $error("busy without process command");

  // a non-final result is always a fire report
  a_mid_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (out_fired && out_accepted && busy))
    else $error("non-final result that is not a fire");

  // no fire is held back once the sequencer is idle
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held fire left after scan");
`endif

endmodule
